[rtl/core/swept_circle_hit_test_core_defines.svh]
// ----------------------------------------------------------------------------
// swept_circle_hit_test_core_defines
// assertion macros for the swept circle hit test core
// ----------------------------------------------------------------------------
`ifndef SWEPT_CIRCLE_HIT_TEST_CORE_DEFINES_SVH
`define SWEPT_CIRCLE_HIT_TEST_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SCH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SCH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SCH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SCH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/scht_pkg.sv]
// ----------------------------------------------------------------------------
// scht_pkg
// shared types and constants of the swept circle hit test core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package scht_pkg;
  localparam int CORDIC_ITERS = 15;
  localparam int CORDIC_START = 9949;
  localparam int ITER_W = 4;

  function automatic logic [13:0] arc_of(input logic [ITER_W-1:0] i);
    logic [13:0] a;
    unique case (i)
      4'd0: a = 14'd8192;
      4'd1: a = 14'd4836;
      4'd2: a = 14'd2555;
      4'd3: a = 14'd1297;
      4'd4: a = 14'd651;
      4'd5: a = 14'd326;
      4'd6: a = 14'd163;
      4'd7: a = 14'd81;
      4'd8: a = 14'd41;
      4'd9: a = 14'd20;
      4'd10: a = 14'd10;
      4'd11: a = 14'd5;
      4'd12: a = 14'd3;
      4'd13: a = 14'd1;
      4'd14: a = 14'd1;
      default: a = 14'd0;
    endcase
    return a;
  endfunction

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the transaction
    logic div_step;   // one restoring division bit
    logic cordic_init;
    logic cordic_step;
    logic samp_init;  // t = -speed
    logic samp_mul;   // products of t with cos and sin
    logic samp_pos;   // round and add offsets
    logic samp_sq;    // square terms
    logic samp_cmp;   // compare and advance t
    logic cur_sq;     // squared current distance
    logic cur_cmp;
  } scht_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic r_zero;
    logic swept;      // speed above radius sum
    logic hit;
  } scht_sts_t;
endpackage
`default_nettype wire

[rtl/core/scht_datapath.sv]
// ----------------------------------------------------------------------------
// scht_datapath
// operand registers, serial divider, cordic and sample distance arithmetic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module scht_datapath #(
  parameter int CNT_W = 13
) (
  input  wire logic                clk,
  input  wire logic [15:0]         in_mover_x,
  input  wire logic [15:0]         in_mover_y,
  input  wire logic [15:0]         in_target_x,
  input  wire logic [15:0]         in_target_y,
  input  wire logic [11:0]         in_mover_radius,
  input  wire logic [11:0]         in_target_radius,
  input  wire logic [11:0]         in_speed,
  input  wire logic [15:0]         in_heading,
  input  wire scht_pkg::scht_cmd_t cmd,
  input  wire logic                hit_clr,
  input  wire logic [3:0]          iter,
  output scht_pkg::scht_sts_t      sts,
  output logic [CNT_W-1:0]         count
);
  logic signed [16:0] dx_r, dy_r;
  logic [12:0]        r_r;
  logic [11:0]        spd_r;
  logic signed [17:0] z_r;
  logic               flip_r;
  logic signed [17:0] cx_r, cy_r;
  logic [12:0]        quo_r;
  logic [13:0]        rem_r;
  logic signed [14:0] t_r;
  logic signed [33:0] px_r, py_r;
  logic signed [18:0] ox_r, oy_r;
  logic [37:0]        sx_r, sy_r;
  logic               hit_r;
  logic signed [16:0] z_nxt;
  logic [13:0]        rem_sh;
  logic signed [17:0] xs, ys;
  logic signed [16:0] hz;
  logic signed [34:0] rx, ry;
  logic [38:0]        dsum;
  logic [25:0]        rr;

  assign hz     = 17'(signed'(in_heading));
  assign rem_sh = {rem_r[12:0], 1'b0};
  assign xs     = cx_r >>> iter;
  assign ys     = cy_r >>> iter;
  assign rx     = 35'(px_r) + 35'sd8192;
  assign ry     = 35'(py_r) + 35'sd8192;
  assign rr     = 26'(r_r) * 26'(r_r);
  assign dsum   = 39'(sx_r) + 39'(sy_r);
  assign z_nxt  = (hz > 17'sd16384) ? hz - 17'sd32768 :
                  (hz < -17'sd16384) ? hz + 17'sd32768 : hz;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r   <= 17'(signed'(in_mover_x)) - 17'(signed'(in_target_x));
      dy_r   <= 17'(signed'(in_mover_y)) - 17'(signed'(in_target_y));
      r_r    <= 13'(in_mover_radius) + 13'(in_target_radius);
      spd_r  <= in_speed;
      z_r    <= 18'(z_nxt);
      flip_r <= (hz > 17'sd16384) || (hz < -17'sd16384);
      // dividend speed + r - 1 shifted in msb first
      quo_r  <= 13'(in_speed) + 13'(in_mover_radius) + 13'(in_target_radius) - 13'd1;
      rem_r  <= '0;
    end
    if (cmd.div_step) begin
      if ({rem_sh[13:1], quo_r[12]} >= {1'b0, r_r}) begin
        rem_r <= {rem_sh[13:1], quo_r[12]} - {1'b0, r_r};
        quo_r <= {quo_r[11:0], 1'b1};
      end else begin
        rem_r <= {rem_sh[13:1], quo_r[12]};
        quo_r <= {quo_r[11:0], 1'b0};
      end
    end
    if (cmd.cordic_init) begin
      cx_r <= 18'sd9949;
      cy_r <= '0;
    end
    if (cmd.cordic_step) begin
      if (z_r >= 0) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        z_r  <= z_r - 18'(scht_pkg::arc_of(iter));
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        z_r  <= z_r + 18'(scht_pkg::arc_of(iter));
      end
      if (iter == 4'(scht_pkg::CORDIC_ITERS - 1) && flip_r) begin
        if (z_r >= 0) begin
          cx_r <= -(cx_r - ys);
          cy_r <= -(cy_r + xs);
        end else begin
          cx_r <= -(cx_r + ys);
          cy_r <= -(cy_r - xs);
        end
      end
    end
    if (cmd.samp_init) t_r <= -15'(spd_r);
    if (cmd.samp_mul) begin
      px_r <= 34'(t_r) * 34'(cx_r);
      py_r <= 34'(t_r) * 34'(cy_r);
    end
    if (cmd.samp_pos) begin
      ox_r <= 19'(dx_r) + 19'(rx >>> 14);
      oy_r <= 19'(dy_r) + 19'(ry >>> 14);
    end
    if (cmd.samp_sq) begin
      sx_r <= 38'(ox_r * ox_r);
      sy_r <= 38'(oy_r * oy_r);
    end
    if (cmd.cur_sq) begin
      sx_r <= 38'(dx_r * dx_r);
      sy_r <= 38'(dy_r * dy_r);
    end
    if (cmd.samp_cmp) t_r <= t_r + 15'(r_r);
    if (hit_clr) hit_r <= 1'b0;
    else if ((cmd.samp_cmp || cmd.cur_cmp) && dsum < 39'(rr)) hit_r <= 1'b1;
  end

  assign sts.r_zero = (r_r == '0);
  assign sts.swept  = (13'(spd_r) > r_r);
  assign sts.hit    = hit_r;
  assign count      = CNT_W'(quo_r);
endmodule
`default_nettype wire

[rtl/core/scht_ctrl.sv]
// ----------------------------------------------------------------------------
// scht_ctrl
// sequencer: divide, cordic, sample loop, current position, result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module scht_ctrl #(
  parameter int MAX_STEPS = 64,
  parameter int CNT_W     = 13
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_hit,
  output logic                     out_steps_capped,
  input  wire scht_pkg::scht_sts_t sts,
  input  wire logic [CNT_W-1:0]    count,
  output scht_pkg::scht_cmd_t      cmd,
  output logic                     hit_clr,
  output logic [3:0]               iter,
  output logic                     busy
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_CORD = 4'd2, S_MUL = 4'd3,
                         S_POS = 4'd4, S_SQ = 4'd5, S_CMP = 4'd6, S_CSQ = 4'd7,
                         S_CCMP = 4'd8, S_OUT = 4'd9;
  localparam int JW = CNT_W + 1;

  logic [3:0]    state_r, state_nxt;
  logic [3:0]    iter_r, iter_nxt;
  logic [JW-1:0] j_r, j_nxt, lim_r, lim_nxt;
  logic          cap_r, cap_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_hit_r, out_hit_nxt;
  logic          out_cap_r, out_cap_nxt;
  logic          acc;

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign iter     = iter_r;

  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    j_nxt         = j_r;
    lim_nxt       = lim_r;
    cap_nxt       = cap_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_hit_nxt   = out_hit_r;
    out_cap_nxt   = out_cap_r;
    cmd           = '0;
    hit_clr       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.load  = 1'b1;
          hit_clr   = 1'b1;
          cap_nxt   = 1'b0;
          iter_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        iter_nxt     = iter_r + 4'd1;
        if (iter_r == 4'd12) begin
          iter_nxt  = '0;
          priority if (sts.r_zero) state_nxt = S_OUT;
          else if (!sts.swept) state_nxt = S_CSQ;
          else begin
            cmd.cordic_init = 1'b1;
            state_nxt       = S_CORD;
          end
        end
      end
      S_CORD: begin
        cmd.cordic_step = 1'b1;
        iter_nxt        = iter_r + 4'd1;
        if (iter_r == 4'(scht_pkg::CORDIC_ITERS - 1)) begin
          cmd.samp_init = 1'b1;
          j_nxt         = '0;
          if (JW'(count) > JW'(MAX_STEPS)) begin
            lim_nxt = JW'(MAX_STEPS);
            cap_nxt = 1'b1;
          end else begin
            lim_nxt = JW'(count);
          end
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin cmd.samp_mul = 1'b1; state_nxt = S_POS; end
      S_POS: begin cmd.samp_pos = 1'b1; state_nxt = S_SQ;  end
      S_SQ:  begin cmd.samp_sq  = 1'b1; state_nxt = S_CMP; end
      S_CMP: begin
        cmd.samp_cmp = 1'b1;
        j_nxt        = j_r + 1'b1;
        state_nxt    = (j_r + 1'b1 >= lim_r) ? S_CSQ : S_MUL;
      end
      S_CSQ:  begin cmd.cur_sq  = 1'b1; state_nxt = S_CCMP; end
      S_CCMP: begin cmd.cur_cmp = 1'b1; state_nxt = S_OUT;  end
      S_OUT: begin
        // hand over once the result register is free or drains this cycle
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = sts.hit;
          out_cap_nxt   = cap_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iter_r      <= '0;
      j_r         <= '0;
      lim_r       <= '0;
      cap_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_hit_r   <= 1'b0;
      out_cap_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      j_r         <= j_nxt;
      lim_r       <= lim_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
      out_hit_r   <= out_hit_nxt;
      out_cap_r   <= out_cap_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_steps_capped = out_cap_r;
endmodule
`default_nettype wire

[rtl/core/swept_circle_hit_test_core.sv]
// ----------------------------------------------------------------------------
// swept_circle_hit_test_core
// swept circle collision test between a moving object and a target
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with the mover, target, radii, speed
//   and heading; one transaction in flight at a time, in_stall is high while
//   a transaction is being worked on or waits for the result register
//   result channel: out_valid / out_stall with out_hit and out_steps_capped
//   from a result register, which holds while out_stall is high
//   sequence: a serial ceil division, then, when the speed exceeds the radius
//   sum, cordic rotation and a sample loop of multiply, position, square and
//   compare (up to MAX_STEPS samples), then the current position square and
//   compare and a transfer state; a zero radius sum goes straight from the
//   division to the transfer, a non-swept test to the current position
//   a new transaction is taken only once the previous one has left the
//   transfer state; samples run one after another on the shared multipliers
//   a stalled result lets the next transaction run; that one waits in the
//   transfer cycle only while the result register is still full
//   reset: synchronous, active low, returns the sequencer to idle, no result
`timescale 1ns / 1ps
`default_nettype none
`include "swept_circle_hit_test_core_defines.svh"
module swept_circle_hit_test_core #(
  parameter int MAX_STEPS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_mover_x,
  input  wire logic [15:0] in_mover_y,
  input  wire logic [15:0] in_target_x,
  input  wire logic [15:0] in_target_y,
  input  wire logic [11:0] in_mover_radius,
  input  wire logic [11:0] in_target_radius,
  input  wire logic [11:0] in_speed,
  input  wire logic [15:0] in_heading,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_hit,
  output logic             out_steps_capped
);
  // step count needs up to 12 bits (speed + r - 1 quotient)
  localparam int CNT_W = 13;

  scht_pkg::scht_cmd_t cmd;
  scht_pkg::scht_sts_t sts;
  logic [CNT_W-1:0]    count;
  logic                hit_clr;
  logic [3:0]          iter;
  logic                busy;

  scht_ctrl #(.MAX_STEPS(MAX_STEPS), .CNT_W(CNT_W)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .out_hit, .out_steps_capped, .sts, .count, .cmd, .hit_clr, .iter, .busy
  );

  scht_datapath #(.CNT_W(CNT_W)) u_dp (
    .clk, .in_mover_x, .in_mover_y, .in_target_x, .in_target_y,
    .in_mover_radius, .in_target_radius, .in_speed, .in_heading,
    .cmd, .hit_clr, .iter, .sts, .count
  );

  // no new transaction while one is at work
  `SCH_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, busy, in_stall)
  // a result that is stalled stays valid
  `SCH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  // a stalled result keeps its flags
  `SCH_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_hit) && $stable(out_steps_capped))
endmodule
`default_nettype wire

[dv/tb_swept_circle_hit_test_core.sv]
// ----------------------------------------------------------------------------
// tb_swept_circle_hit_test_core
// self-checking bench: directed table then random swept and static tests, each result
// compared against a typed-in expectation or a behavioural predictor of the hit test
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_swept_circle_hit_test_core;
  localparam int MAX_STEPS = 64;
  localparam int N_RANDOM = 900;
  localparam longint CYCLE_LIMIT = 2000000;

  // one transaction worth of inputs
  typedef struct {
    logic [15:0] mx, my, tx, ty;
    logic [11:0] mr, tr, spd;
    logic [15:0] hd;
    logic        chk;   // typed-in expectation present
    logic        ehit;
    logic        ecap;
  } shot_t;

  typedef struct {
    logic hit;
    logic cap;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [15:0] in_mover_x, in_mover_y, in_target_x, in_target_y;
  logic [11:0] in_mover_radius, in_target_radius, in_speed;
  logic [15:0] in_heading;
  logic out_valid;
  logic out_stall;
  logic out_hit;
  logic out_steps_capped;

  swept_circle_hit_test_core #(.MAX_STEPS(MAX_STEPS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mover_x(in_mover_x), .in_mover_y(in_mover_y),
    .in_target_x(in_target_x), .in_target_y(in_target_y),
    .in_mover_radius(in_mover_radius), .in_target_radius(in_target_radius),
    .in_speed(in_speed), .in_heading(in_heading),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hit(out_hit), .out_steps_capped(out_steps_capped)
  );

  verdict_t pending_verdicts[$];
  shot_t    directed[$];
  int       mismatches;
  longint   cycles;
  bit       hold_off;      // long receiver hold-off request
  bit       quiet;         // stretch with no idling

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor shift toward minus infinity
  function automatic longint fshr(input longint v, input int n);
    return v >>> n;
  endfunction

  // rotation cordic, Q1.14 cosine and sine of a binary angle
  function automatic void heading_trig(input logic [15:0] hd, output longint c,
                                       output longint s);
    longint z, x, y, xs, ys;
    bit flip;
    int arc [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5,
                     3, 1, 1};
    z = longint'($signed(hd));
    x = 9949;
    y = 0;
    flip = 0;
    if (z > 16384) begin
      z -= 32768;
      flip = 1;
    end else if (z < -16384) begin
      z += 32768;
      flip = 1;
    end
    for (int i = 0; i < 15; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= arc[i];
      end else begin
        x += ys; y -= xs; z += arc[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // expected hit and cap flags for one transaction
  function automatic verdict_t predict_hit(input shot_t t);
    verdict_t v;
    longint dx, dy, r, sp, rr, cnt, c, s, p, px, py;
    v.hit = 0;
    v.cap = 0;
    dx = longint'($signed(t.mx)) - longint'($signed(t.tx));
    dy = longint'($signed(t.my)) - longint'($signed(t.ty));
    r  = longint'(t.mr) + longint'(t.tr);
    sp = longint'(t.spd);
    rr = r * r;
    if (r != 0) begin
      if (sp > r) begin
        cnt = (sp + r - 1) / r;
        if (cnt > MAX_STEPS) begin
          cnt = MAX_STEPS;
          v.cap = 1;
        end
        heading_trig(t.hd, c, s);
        p = -sp;
        for (longint j = 0; j < cnt && !v.hit; j++) begin
          px = dx + fshr(p * c + 8192, 14);
          py = dy + fshr(p * s + 8192, 14);
          if (px * px + py * py < rr) v.hit = 1;
          p += r;
        end
      end
      if (dx * dx + dy * dy < rr) v.hit = 1;
    end
    return v;
  endfunction

  function automatic shot_t mk(input int mx, my, tx, ty, mr, tr, spd, hd,
                               input bit chk = 0, input bit eh = 0,
                               input bit ec = 0);
    shot_t t;
    t.mx = 16'(mx); t.my = 16'(my); t.tx = 16'(tx); t.ty = 16'(ty);
    t.mr = 12'(mr); t.tr = 12'(tr); t.spd = 12'(spd); t.hd = 16'(hd);
    t.chk = chk; t.ehit = eh; t.ecap = ec;
    return t;
  endfunction

  // random transaction: mostly swept paths aimed near the target
  function automatic shot_t random_shot();
    shot_t t;
    int kind;
    kind = $urandom_range(0, 9);
    t = mk($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 4095),
           $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom);
    if (kind < 6) begin
      // small radii, target near the path
      t.mr = 12'($urandom_range(0, 200));
      t.tr = 12'($urandom_range(0, 200));
      t.tx = t.mx + 16'($urandom_range(0, 4000)) - 16'd2000;
      t.ty = t.my + 16'($urandom_range(0, 4000)) - 16'd2000;
      if (kind == 0) begin
        t.mr = 12'($urandom_range(0, 20));
        t.tr = 12'($urandom_range(0, 20));
      end
    end
    return t;
  endfunction

  task automatic send(input shot_t t);
    verdict_t v;
    v = predict_hit(t);
    if (t.chk && (v.hit !== t.ehit || v.cap !== t.ecap))
      $display("note: table row disagrees with predictor");
    if (t.chk) begin
      v.hit = t.ehit;
      v.cap = t.ecap;
    end
    // sender idles now and then
    while (!quiet && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mover_x       <= t.mx;
    in_mover_y       <= t.my;
    in_target_x      <= t.tx;
    in_target_y      <= t.ty;
    in_mover_radius  <= t.mr;
    in_target_radius <= t.tr;
    in_speed         <= t.spd;
    in_heading       <= t.hd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_verdicts.push_back(v);
  endtask

  // receiver stall process with one long hold-off
  initial begin
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        for (int k = 0; k < 400; k++) @(posedge clk);
        hold_off = 0;
      end
      out_stall <= !quiet && ($urandom_range(0, 99) < 11);
    end
  end

  // result checker
  always @(posedge clk) begin
    verdict_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result hit=%0b", out_hit);
      end else begin
        e = pending_verdicts.pop_front();
        if (out_hit !== e.hit || out_steps_capped !== e.cap) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: hit exp %0b got %0b, capped exp %0b got %0b",
                     e.hit, out_hit, e.cap, out_steps_capped);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    cycles = 0;
    hold_off = 0;
    quiet = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mover_x = '0; in_mover_y = '0; in_target_x = '0; in_target_y = '0;
    in_mover_radius = '0; in_target_radius = '0; in_speed = '0;
    in_heading = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: expectations typed where obvious
    directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));          // zero radius
    directed.push_back(mk(0, 0, 0, 0, 0, 0, 4095, 0, 1, 0, 0));       // zero radius, fast
    directed.push_back(mk(0, 0, 0, 0, 1, 0, 0, 0, 1, 1, 0));          // same spot
    directed.push_back(mk(16, 0, 0, 0, 8, 8, 0, 0, 1, 0, 0));         // touching: strict
    directed.push_back(mk(15, 0, 0, 0, 8, 8, 16, 0, 1, 1, 0));        // speed equals r
    directed.push_back(mk(32767, 32767, -32768, -32768, 4095, 4095, 0, 0, 1, 0, 0));
    directed.push_back(mk(-32768, -32768, 32767, 32767, 0, 1, 4095, 16'hFFFF,
                          1, 0, 1));                                 // capped, far away
    directed.push_back(mk(0, 0, 0, 0, 1, 1, 4095, 0, 1, 1, 1));       // capped, sitting on it
    directed.push_back(mk(0, 0, 0, 0, 4095, 4095, 4095, 0, 1, 1, 0));
    directed.push_back(mk(320, 0, 0, 0, 8, 8, 640, 0));               // sweeps through
    directed.push_back(mk(0, 320, 0, 0, 8, 8, 640, 16384));
    directed.push_back(mk(-320, 0, 0, 0, 8, 8, 640, 32768));
    directed.push_back(mk(0, -320, 0, 0, 8, 8, 640, 49152));
    directed.push_back(mk(320, 320, 0, 0, 8, 8, 960, 8192));
    directed.push_back(mk(320, 0, 0, 0, 2, 2, 256, 0));               // exactly 64 steps
    directed.push_back(mk(320, 0, 0, 0, 2, 2, 257, 0));               // 65 steps, capped
    directed.push_back(mk(100, 50, 0, 0, 30, 30, 400, 16385));
    directed.push_back(mk(100, 50, 0, 0, 30, 30, 400, 49151));
    directed.push_back(mk(-100, 50, 0, 0, 3, 9, 2000, 16'h8001));
    foreach (directed[i]) send(directed[i]);

    // random part, with a quiet stretch and one long hold-off
    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= 300 && n < 400);
      if (n == 500) hold_off = 1;
      send(random_shot());
    end
    quiet = 0;
    in_valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
